FILE: hdl/oale_pkg.sv
// Shared types and constants of the ordered array list engine.
package oale_pkg;

   localparam int REQ_BITS          = 3;
   localparam int KEY_BITS          = 8;
   localparam int POS_BITS          = 5;
   localparam int COUNT_BITS        = 5;
   localparam int STATUS_BITS       = 2;
   localparam int PORT_PAYLOAD_BITS = 32;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_INS_HEAD = 3'd0,
      REQ_INS_TAIL = 3'd1,
      REQ_INS_AT   = 3'd2,
      REQ_DEL_HEAD = 3'd3,
      REQ_DEL_TAIL = 3'd4,
      REQ_DEL_KEY  = 3'd5,
      REQ_READ     = 3'd6,
      REQ_CLEAR    = 3'd7
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_INSERT,
      CMD_PACK,
      CMD_READ,
      CMD_DROP_TAIL,
      CMD_CLEAR
   } cmd_kind_type;

   typedef enum logic [1:0] {
      AT_HEAD,
      AT_TAIL,
      AT_POS
   } ins_mode_type;

   typedef struct packed {
      cmd_kind_type kind;
      ins_mode_type ins_mode;
      logic         drop_head;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN,
      S_PACK,
      S_DRAIN,
      S_PUT,
      S_RDWAIT
   } state_type;

endpackage

FILE: hdl/oale_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oale_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/oale_front.sv
// Request decode and command queue of the ordered array list engine.
module oale_front #(
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [oale_pkg::REQ_BITS-1:0]             req_type,
   input  logic [oale_pkg::PORT_PAYLOAD_BITS-1:0]    req_entry_payload,
   input  logic [oale_pkg::KEY_BITS-1:0]             req_entry_key,
   input  logic [oale_pkg::POS_BITS-1:0]             req_position,
   output logic                                      q_valid,
   input  logic                                      q_pop,
   output oale_pkg::cmd_type                         q_cmd,
   output logic [PAYLOAD_BITS-1:0]                   q_payload,
   output logic [oale_pkg::KEY_BITS-1:0]             q_key,
   output logic [oale_pkg::POS_BITS-1:0]             q_pos
);

   localparam int QPTR_BITS = (oale_pkg::QUEUE_DEPTH > 1) ? $clog2(oale_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(oale_pkg::QUEUE_DEPTH + 1);

   oale_pkg::cmd_type                 cmd_in;
   logic [PAYLOAD_BITS+31:0]          pay_wide;
   logic [PAYLOAD_BITS-1:0]           pay_in;
   logic                              push;

   oale_pkg::cmd_type                 cmd_q_ff [oale_pkg::QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0]           pay_q_ff [oale_pkg::QUEUE_DEPTH];
   logic [oale_pkg::KEY_BITS-1:0]     key_q_ff [oale_pkg::QUEUE_DEPTH];
   logic [oale_pkg::POS_BITS-1:0]     pos_q_ff [oale_pkg::QUEUE_DEPTH];

   logic [QPTR_BITS-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]              fill_ff, fill_in;

   always_comb begin
      cmd_in = '{kind: oale_pkg::CMD_CLEAR, ins_mode: oale_pkg::AT_HEAD, drop_head: 1'b0};
      case (oale_pkg::req_code_type'(req_type))
         oale_pkg::REQ_INS_HEAD: begin
            cmd_in.kind     = oale_pkg::CMD_INSERT;
            cmd_in.ins_mode = oale_pkg::AT_HEAD;
         end
         oale_pkg::REQ_INS_TAIL: begin
            cmd_in.kind     = oale_pkg::CMD_INSERT;
            cmd_in.ins_mode = oale_pkg::AT_TAIL;
         end
         oale_pkg::REQ_INS_AT: begin
            cmd_in.kind     = oale_pkg::CMD_INSERT;
            cmd_in.ins_mode = oale_pkg::AT_POS;
         end
         oale_pkg::REQ_DEL_HEAD: begin
            cmd_in.kind      = oale_pkg::CMD_PACK;
            cmd_in.drop_head = 1'b1;
         end
         oale_pkg::REQ_DEL_TAIL: begin
            cmd_in.kind = oale_pkg::CMD_DROP_TAIL;
         end
         oale_pkg::REQ_DEL_KEY: begin
            cmd_in.kind = oale_pkg::CMD_PACK;
         end
         oale_pkg::REQ_READ: begin
            cmd_in.kind = oale_pkg::CMD_READ;
         end
         default: begin
            cmd_in.kind = oale_pkg::CMD_CLEAR;
         end
      endcase
   end

   assign pay_wide = {{PAYLOAD_BITS{1'b0}}, req_entry_payload};
   assign pay_in   = pay_wide[PAYLOAD_BITS-1:0];

   assign busy    = (fill_ff == QCNT_BITS'(oale_pkg::QUEUE_DEPTH));
   assign push    = start & ~busy;
   assign q_valid = (fill_ff != '0);

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_in;
         pay_q_ff[wr_ptr_ff] <= pay_in;
         key_q_ff[wr_ptr_ff] <= req_entry_key;
         pos_q_ff[wr_ptr_ff] <= req_position;
      end
   end

   assign q_cmd     = cmd_q_ff[rd_ptr_ff];
   assign q_payload = pay_q_ff[rd_ptr_ff];
   assign q_key     = key_q_ff[rd_ptr_ff];
   assign q_pos     = pos_q_ff[rd_ptr_ff];

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (fill_ff != '0))
      else $error("command popped from an empty queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_BITS'(oale_pkg::QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

FILE: hdl/oale_back.sv
// Command execution: list store walk, count and result register.
module oale_back #(
   parameter int LIST_DEPTH   = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  oale_pkg::cmd_type                      q_cmd,
   input  logic [PAYLOAD_BITS-1:0]                q_payload,
   input  logic [oale_pkg::KEY_BITS-1:0]          q_key,
   input  logic [oale_pkg::POS_BITS-1:0]          q_pos,
   output logic                                   q_pop,
   output logic                                   rsp_strobe,
   output logic [oale_pkg::COUNT_BITS-1:0]        rsp_list_count,
   output logic [oale_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [oale_pkg::PORT_PAYLOAD_BITS-1:0] rsp_read_payload,
   output logic [oale_pkg::KEY_BITS-1:0]          rsp_read_key
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int XW = (CW > oale_pkg::POS_BITS) ? CW : oale_pkg::POS_BITS;
   localparam int EW = PAYLOAD_BITS + oale_pkg::KEY_BITS;

   oale_pkg::state_type               state_ff, state_in;
   oale_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [PAYLOAD_BITS-1:0]           pay_ff, pay_in;
   logic [oale_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [AW-1:0]                     at_ff, at_in;
   logic [AW-1:0]                     rd_ff, rd_in;
   logic [CW-1:0]                     wr_ff, wr_in;
   logic                              wb_valid_ff, wb_valid_in;
   logic [AW-1:0]                     wb_addr_ff, wb_addr_in;
   logic [CW-1:0]                     count_ff, count_in;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [oale_pkg::COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   oale_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [oale_pkg::PORT_PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [oale_pkg::KEY_BITS-1:0]     rsp_key_ff, rsp_key_in;

   logic                              ram_we, ram_re;
   logic [AW-1:0]                     ram_waddr, ram_raddr;
   logic [EW-1:0]                     ram_wdata, ram_rdata;

   logic [XW-1:0]                     cnt_x, pos_x, at_x;
   logic [CW-1:0]                     cnt_dec;
   logic [AW-1:0]                     last_addr;
   logic                              is_full, is_empty, at_bad, at_end, rd_bad;
   logic                              is_pack, keep;
   logic [oale_pkg::KEY_BITS-1:0]     wb_key;
   logic [CW+oale_pkg::COUNT_BITS-1:0] cnt_wide;
   logic [PAYLOAD_BITS+31:0]          rp_wide;

   oale_ram #(
      .WIDTH (EW),
      .DEPTH (LIST_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // classify the queue head against the current count
   always_comb begin
      cnt_x    = XW'(count_ff);
      pos_x    = XW'(q_pos);
      is_full  = (count_ff == CW'(LIST_DEPTH));
      is_empty = (count_ff == '0);
      cnt_dec  = count_ff - 1'b1;
      last_addr = cnt_dec[AW-1:0];
      case (q_cmd.ins_mode)
         oale_pkg::AT_HEAD: at_x = '0;
         oale_pkg::AT_TAIL: at_x = cnt_x;
         default:           at_x = pos_x;
      endcase
      at_bad = (at_x > cnt_x);
      at_end = (at_x == cnt_x);
      rd_bad = (pos_x >= cnt_x);
   end

   assign is_pack = (cmd_ff.kind == oale_pkg::CMD_PACK);
   assign wb_key  = ram_rdata[EW-1:PAYLOAD_BITS];
   assign keep    = cmd_ff.drop_head ? (wb_addr_ff != '0) : (wb_key != key_ff);

   // store write port: walk write-back, or the new entry
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wb_addr_ff;
      ram_wdata = ram_rdata;
      if (state_ff == oale_pkg::S_PUT) begin
         ram_we    = 1'b1;
         ram_waddr = at_ff;
         ram_wdata = {key_ff, pay_ff};
      end else if (wb_valid_ff) begin
         ram_we    = is_pack ? keep : 1'b1;
         ram_waddr = is_pack ? wr_ff[AW-1:0] : wb_addr_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oale_pkg::S_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  oale_pkg::CMD_INSERT: begin
                     if (!is_full && !at_bad) begin
                        state_in = at_end ? oale_pkg::S_PUT : oale_pkg::S_OPEN;
                     end
                  end
                  oale_pkg::CMD_PACK: begin
                     if (!is_empty) begin
                        state_in = oale_pkg::S_PACK;
                     end
                  end
                  oale_pkg::CMD_READ: begin
                     if (!is_empty && !rd_bad) begin
                        state_in = oale_pkg::S_RDWAIT;
                     end
                  end
                  default: state_in = oale_pkg::S_IDLE;
               endcase
            end
         end
         oale_pkg::S_OPEN: begin
            if (rd_ff == at_ff) begin
               state_in = oale_pkg::S_DRAIN;
            end
         end
         oale_pkg::S_PACK: begin
            if (rd_ff == last_addr) begin
               state_in = oale_pkg::S_DRAIN;
            end
         end
         oale_pkg::S_DRAIN: begin
            state_in = is_pack ? oale_pkg::S_IDLE : oale_pkg::S_PUT;
         end
         oale_pkg::S_PUT:    state_in = oale_pkg::S_IDLE;
         oale_pkg::S_RDWAIT: state_in = oale_pkg::S_IDLE;
         default:            state_in = oale_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop         = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = rd_ff;
      cmd_in        = cmd_ff;
      pay_in        = pay_ff;
      key_in        = key_ff;
      at_in         = at_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      wb_valid_in   = 1'b0;
      wb_addr_in    = wb_addr_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = oale_pkg::ST_DONE;
      rsp_pay_in    = '0;
      rsp_key_in    = '0;
      rp_wide       = {32'd0, ram_rdata[PAYLOAD_BITS-1:0]};

      if (wb_valid_ff && is_pack && keep) begin
         wr_in = wr_ff + 1'b1;
      end

      case (state_ff)
         oale_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               pay_in = q_payload;
               key_in = q_key;
               at_in  = at_x[AW-1:0];
               wr_in  = '0;
               rd_in  = (q_cmd.kind == oale_pkg::CMD_INSERT) ? last_addr : '0;
               case (q_cmd.kind)
                  oale_pkg::CMD_INSERT: begin
                     if (is_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = oale_pkg::ST_FULL;
                     end else if (at_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = oale_pkg::ST_BADPOS;
                     end
                  end
                  oale_pkg::CMD_PACK: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = oale_pkg::ST_EMPTY;
                     end
                  end
                  oale_pkg::CMD_READ: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = oale_pkg::ST_EMPTY;
                     end else if (rd_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = oale_pkg::ST_BADPOS;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_x[AW-1:0];
                     end
                  end
                  oale_pkg::CMD_DROP_TAIL: begin
                     rsp_strobe_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = oale_pkg::ST_EMPTY;
                     end else begin
                        count_in = cnt_dec;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     count_in      = '0;
                  end
               endcase
            end
         end
         oale_pkg::S_OPEN: begin
            ram_re      = 1'b1;
            wb_valid_in = 1'b1;
            wb_addr_in  = rd_ff + 1'b1;
            rd_in       = rd_ff - 1'b1;
         end
         oale_pkg::S_PACK: begin
            ram_re      = 1'b1;
            wb_valid_in = 1'b1;
            wb_addr_in  = rd_ff;
            rd_in       = rd_ff + 1'b1;
         end
         oale_pkg::S_DRAIN: begin
            if (is_pack) begin
               count_in      = wr_in;
               rsp_strobe_in = 1'b1;
            end
         end
         oale_pkg::S_PUT: begin
            count_in      = count_ff + 1'b1;
            rsp_strobe_in = 1'b1;
         end
         oale_pkg::S_RDWAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_pay_in    = rp_wide[31:0];
            rsp_key_in    = ram_rdata[EW-1:PAYLOAD_BITS];
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase

      cnt_wide     = {{oale_pkg::COUNT_BITS{1'b0}}, count_in};
      rsp_count_in = cnt_wide[oale_pkg::COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= oale_pkg::S_IDLE;
         count_ff      <= '0;
         wb_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         wb_valid_ff   <= wb_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pay_ff        <= pay_in;
      key_ff        <= key_in;
      at_ff         <= at_in;
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      wb_addr_ff    <= wb_addr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_list_count   = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_payload = rsp_pay_ff;
   assign rsp_read_key     = rsp_key_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("store written and read at the same entry");

   a_pack_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oale_pkg::S_PACK) |-> (wr_ff <= CW'(rd_ff)))
      else $error("compaction write index passed read index");

   a_count_reported: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> rsp_strobe_ff)
      else $error("count changed without a result");

endmodule

FILE: hdl/ordered_array_list_engine.sv
// Top level of the ordered array list engine.
//
//   channel   direction  handshake               payload
//   request   in         start high, busy low    req_type, req_entry_payload,
//                                                req_entry_key, req_position
//   result    out        rsp_strobe, one cycle   rsp_list_count, rsp_status,
//                                                rsp_read_payload, rsp_read_key
//
// A two-item command queue sits in front of the executor; busy is high while it is full.
// Insert at position p walks the store from the tail down to p, moving each entry up,
// then writes the new entry; insert at the end writes it directly. Delete head and
// delete by key compact the list in one walk, one entry per cycle through the single
// store read port. Read takes one store read; delete tail and clear need no walk.
// Reset clears the count and the queue; store contents are undefined until written.
// The receiver cannot stall: every result is taken in its strobe cycle.
module ordered_array_list_engine #(
   parameter int LIST_DEPTH   = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [oale_pkg::REQ_BITS-1:0]          req_type,
   input  logic [oale_pkg::PORT_PAYLOAD_BITS-1:0] req_entry_payload,
   input  logic [oale_pkg::KEY_BITS-1:0]          req_entry_key,
   input  logic [oale_pkg::POS_BITS-1:0]          req_position,
   output logic                                   rsp_strobe,
   output logic [oale_pkg::COUNT_BITS-1:0]        rsp_list_count,
   output logic [oale_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [oale_pkg::PORT_PAYLOAD_BITS-1:0] rsp_read_payload,
   output logic [oale_pkg::KEY_BITS-1:0]          rsp_read_key
);

   logic                          q_valid;
   logic                          q_pop;
   oale_pkg::cmd_type             q_cmd;
   logic [PAYLOAD_BITS-1:0]       q_payload;
   logic [oale_pkg::KEY_BITS-1:0] q_key;
   logic [oale_pkg::POS_BITS-1:0] q_pos;

   oale_front #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_entry_payload (req_entry_payload),
      .req_entry_key     (req_entry_key),
      .req_position      (req_position),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_cmd             (q_cmd),
      .q_payload         (q_payload),
      .q_key             (q_key),
      .q_pos             (q_pos)
   );

   oale_back #(
      .LIST_DEPTH   (LIST_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_payload        (q_payload),
      .q_key            (q_key),
      .q_pos            (q_pos),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_list_count   (rsp_list_count),
      .rsp_status       (rsp_status),
      .rsp_read_payload (rsp_read_payload),
      .rsp_read_key     (rsp_read_key)
   );

endmodule

FILE: test/list_check_pkg.sv
// Scoreboard for the ordered array list engine: predicts each result and checks it.
package list_check_pkg;
   import oale_pkg::*;

   localparam int LIST_ENTRIES = 16;

   typedef struct packed {
      logic [COUNT_BITS-1:0]        count;
      status_type                   status;
      logic [PORT_PAYLOAD_BITS-1:0] rd_payload;
      logic [KEY_BITS-1:0]          rd_key;
   } list_result_type;

   class list_scoreboard;
      logic [PORT_PAYLOAD_BITS-1:0] payloads[LIST_ENTRIES];
      logic [KEY_BITS-1:0]          keys[LIST_ENTRIES];
      int                           count;
      list_result_type              awaited[$];
      int errors, checked;
      int inserts, deletes, reads, clears;
      int full_hits, badpos_hits, empty_hits, peak;

      function new();
         count = 0;
         errors = 0;
         checked = 0;
         inserts = 0;
         deletes = 0;
         reads = 0;
         clears = 0;
         full_hits = 0;
         badpos_hits = 0;
         empty_hits = 0;
         peak = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void log_error(string msg);
         errors++;
         if (errors <= 10) $display("ERROR: %s", msg);
      endfunction

      function void note_request(req_code_type req, logic [PORT_PAYLOAD_BITS-1:0] pay,
                                 logic [KEY_BITS-1:0] key, logic [POS_BITS-1:0] pos);
         list_result_type r;
         int k, wr, at;
         r = '0;
         r.status = ST_DONE;
         case (req)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
               inserts++;
               if (req == REQ_INS_HEAD) at = 0;
               else if (req == REQ_INS_TAIL) at = count;
               else at = int'(pos);
               if (count >= LIST_ENTRIES) begin
                  r.status = ST_FULL;
               end else if (at > count) begin
                  r.status = ST_BADPOS;
               end else begin
                  for (k = count; k > at; k--) begin
                     payloads[k] = payloads[k-1];
                     keys[k] = keys[k-1];
                  end
                  payloads[at] = pay;
                  keys[at] = key;
                  count++;
               end
            end
            REQ_DEL_HEAD: begin
               deletes++;
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  for (k = 0; k + 1 < count; k++) begin
                     payloads[k] = payloads[k+1];
                     keys[k] = keys[k+1];
                  end
                  count--;
               end
            end
            REQ_DEL_TAIL: begin
               deletes++;
               if (count == 0) r.status = ST_EMPTY;
               else count--;
            end
            REQ_DEL_KEY: begin
               deletes++;
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  wr = 0;
                  for (k = 0; k < count; k++) begin
                     if (keys[k] != key) begin
                        payloads[wr] = payloads[k];
                        keys[wr] = keys[k];
                        wr++;
                     end
                  end
                  count = wr;
               end
            end
            REQ_READ: begin
               reads++;
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else if (pos >= count) begin
                  r.status = ST_BADPOS;
               end else begin
                  r.rd_payload = payloads[pos];
                  r.rd_key = keys[pos];
               end
            end
            default: begin
               clears++;
               count = 0;
            end
         endcase
         if (r.status == ST_FULL) full_hits++;
         if (r.status == ST_BADPOS) badpos_hits++;
         if (r.status == ST_EMPTY) empty_hits++;
         if (count > peak) peak = count;
         r.count = COUNT_BITS'(count);
         awaited.push_back(r);
      endfunction

      function void check_result(logic [COUNT_BITS-1:0] cnt, logic [STATUS_BITS-1:0] st,
                                 logic [PORT_PAYLOAD_BITS-1:0] rpay,
                                 logic [KEY_BITS-1:0] rkey);
         list_result_type want;
         if (awaited.size() == 0) begin
            log_error($sformatf("result with none awaited: count %0d status %0d", cnt, st));
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (cnt !== want.count || st !== want.status || rpay !== want.rd_payload ||
             rkey !== want.rd_key) begin
            log_error($sformatf({"result %0d: expected count %0d status %0d payload %h key %h,",
                                 " got count %0d status %0d payload %h key %h"},
                                checked, want.count, want.status, want.rd_payload,
                                want.rd_key, cnt, st, rpay, rkey));
         end
      endfunction

      function void close_out();
         if (awaited.size() > 0) begin
            log_error($sformatf("%0d results never arrived", awaited.size()));
            errors += awaited.size() - 1;
            awaited.delete();
         end
      endfunction
   endclass

endpackage

FILE: test/tb_top.sv
// Testbench top for the ordered array list engine: directed and random list requests.
module tb_top;
   import oale_pkg::*;
   import list_check_pkg::*;

   localparam int PHASE_GROW   = 0;
   localparam int PHASE_SHRINK = 1;
   localparam int PHASE_MIXED  = 2;
   localparam int RANDOM_ITEMS = 550;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [REQ_BITS-1:0]          req_type;
   logic [PORT_PAYLOAD_BITS-1:0] req_entry_payload;
   logic [KEY_BITS-1:0]          req_entry_key;
   logic [POS_BITS-1:0]          req_position;
   logic                         rsp_strobe;
   logic [COUNT_BITS-1:0]        rsp_list_count;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic [PORT_PAYLOAD_BITS-1:0] rsp_read_payload;
   logic [KEY_BITS-1:0]          rsp_read_key;

   list_scoreboard sb;
   int             burst_left;
   int             sent;

   ordered_array_list_engine #(
      .LIST_DEPTH   (LIST_ENTRIES),
      .PAYLOAD_BITS (PORT_PAYLOAD_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_entry_payload (req_entry_payload),
      .req_entry_key     (req_entry_key),
      .req_position      (req_position),
      .rsp_strobe        (rsp_strobe),
      .rsp_list_count    (rsp_list_count),
      .rsp_status        (rsp_status),
      .rsp_read_payload  (rsp_read_payload),
      .rsp_read_key      (rsp_read_key)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         sb.check_result(rsp_list_count, rsp_status, rsp_read_payload, rsp_read_key);
   end

   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1: return 8'h00;
         2, 3: return 8'h5A;
         4, 5: return 8'hA5;
         6: return 8'hFF;
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         req_type <= REQ_BITS'($urandom);
         req_entry_payload <= $urandom;
         req_entry_key <= KEY_BITS'($urandom);
         req_position <= POS_BITS'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_item(req_code_type req, logic [PORT_PAYLOAD_BITS-1:0] pay,
                            logic [KEY_BITS-1:0] key, logic [POS_BITS-1:0] pos);
      start <= 1'b1;
      req_type <= req;
      req_entry_payload <= pay;
      req_entry_key <= key;
      req_position <= pos;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(req, pay, key, pos);
      sent++;
   endtask

   task automatic paced_send(req_code_type req, logic [PORT_PAYLOAD_BITS-1:0] pay,
                             logic [KEY_BITS-1:0] key, logic [POS_BITS-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(40, 80);
         end else begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            pause(gap);
         end
      end
      burst_left--;
      send_item(req, pay, key, pos);
   endtask

   task automatic random_item(int mode);
      req_code_type                 req;
      logic [PORT_PAYLOAD_BITS-1:0] pay;
      logic [KEY_BITS-1:0]          key;
      logic [POS_BITS-1:0]          pos;
      int                           roll;
      roll = $urandom_range(0, 99);
      if (mode == PHASE_GROW) begin
         if (roll < 25) req = REQ_INS_HEAD;
         else if (roll < 50) req = REQ_INS_TAIL;
         else if (roll < 80) req = REQ_INS_AT;
         else if (roll < 92) req = REQ_READ;
         else req = REQ_DEL_TAIL;
      end else if (mode == PHASE_SHRINK) begin
         if (roll < 25) req = REQ_DEL_HEAD;
         else if (roll < 50) req = REQ_DEL_TAIL;
         else if (roll < 75) req = REQ_DEL_KEY;
         else if (roll < 90) req = REQ_READ;
         else if (roll < 97) req = REQ_INS_AT;
         else req = REQ_CLEAR;
      end else begin
         if (roll < 3) req = REQ_CLEAR;
         else req = req_code_type'($urandom_range(0, 6));
      end
      case ($urandom_range(0, 9))
         0: pay = '0;
         1: pay = '1;
         default: pay = $urandom;
      endcase
      key = pick_key();
      if (req == REQ_DEL_KEY && sb.count > 0 && $urandom_range(0, 9) < 6)
         key = sb.keys[$urandom_range(0, sb.count - 1)];
      pos = POS_BITS'($urandom_range(0, 31));
      if (req == REQ_INS_AT && $urandom_range(0, 99) < 85)
         pos = POS_BITS'($urandom_range(0, sb.count));
      if (req == REQ_READ && sb.count > 0 && $urandom_range(0, 99) < 85)
         pos = POS_BITS'($urandom_range(0, sb.count - 1));
      paced_send(req, pay, key, pos);
   endtask

   initial begin
      int i, mode, phase_end;
      sb = new();
      burst_left = 0;
      sent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= REQ_INS_HEAD;
      req_entry_payload <= '0;
      req_entry_key <= '0;
      req_position <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd0);
      paced_send(REQ_DEL_HEAD, $urandom, KEY_BITS'($urandom), POS_BITS'($urandom));
      paced_send(REQ_DEL_TAIL, $urandom, KEY_BITS'($urandom), POS_BITS'($urandom));
      paced_send(REQ_DEL_KEY, $urandom, 8'h00, POS_BITS'($urandom));
      paced_send(REQ_CLEAR, $urandom, KEY_BITS'($urandom), POS_BITS'($urandom));
      paced_send(REQ_INS_AT, 32'h1234_5678, 8'h11, 5'd1);
      paced_send(REQ_INS_AT, 32'h0000_0000, 8'h00, 5'd0);
      paced_send(REQ_INS_HEAD, 32'hFFFF_FFFF, 8'hFF, 5'd31);
      paced_send(REQ_INS_TAIL, 32'hA5A5_A5A5, 8'h00, 5'd16);
      paced_send(REQ_INS_AT, 32'h5A5A_5A5A, 8'h5A, 5'd1);
      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd31);
      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd4);
      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd0);
      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd3);
      paced_send(REQ_DEL_KEY, $urandom, 8'h00, POS_BITS'($urandom));
      paced_send(REQ_DEL_KEY, $urandom, 8'h77, POS_BITS'($urandom));
      while (sb.count < LIST_ENTRIES)
         paced_send(REQ_INS_AT, $urandom, pick_key(), POS_BITS'($urandom_range(0, sb.count)));
      paced_send(REQ_INS_AT, $urandom, KEY_BITS'($urandom), 5'd31);
      paced_send(REQ_INS_HEAD, $urandom, KEY_BITS'($urandom), POS_BITS'($urandom));
      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd15);
      paced_send(REQ_READ, $urandom, KEY_BITS'($urandom), 5'd16);
      paced_send(REQ_CLEAR, $urandom, KEY_BITS'($urandom), POS_BITS'($urandom));

      mode = PHASE_GROW;
      phase_end = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= phase_end) begin
            mode = $urandom_range(PHASE_GROW, PHASE_MIXED);
            phase_end = i + $urandom_range(20, 60);
         end
         random_item(mode);
      end
      start <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (2 * LIST_ENTRIES + 8) @(posedge clock);
      sb.close_out();
      $display("Sent %0d requests (%0d inserts, %0d deletes, %0d reads, %0d clears), %0d checked.",
               sent, sb.inserts, sb.deletes, sb.reads, sb.clears, sb.checked);
      $display("Full rejects %0d, bad positions %0d, empty rejects %0d, peak count %0d.",
               sb.full_hits, sb.badpos_hits, sb.empty_hits, sb.peak);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
